// File: src/pwlct_pkg.sv
package pwlct_pkg;

  localparam int MAX_POINTS = 64;

  localparam int REQW = 3;
  localparam int STW  = 2;
  localparam int PCW  = 7;
  localparam int XW   = 32;
  localparam int AVW  = 64;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int OPW  = XW + 2;
  localparam int PW   = 2 * OPW;
  localparam int NW   = 3 * XW;
  localparam int QW   = NW + 1;
  localparam int DVW  = XW + 2;
  localparam int ACW  = PW + AW + 1;
  localparam int DCW  = $clog2(NW + 1);

  localparam logic [REQW-1:0] REQ_APPEND  = 3'd0;
  localparam logic [REQW-1:0] REQ_CLEAR   = 3'd1;
  localparam logic [REQW-1:0] REQ_LOOKUP  = 3'd2;
  localparam logic [REQW-1:0] REQ_INVERSE = 3'd3;
  localparam logic [REQW-1:0] REQ_INTEG   = 3'd4;

  localparam logic [STW-1:0] ST_OK   = 2'd0;
  localparam logic [STW-1:0] ST_FEW  = 2'd1;
  localparam logic [STW-1:0] ST_FULL = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_FIN, S_MWAIT, S_DIV,
    S_L_FIRST, S_L_LAST, S_L_SCAN,
    S_I_FIRST, S_I_QQ, S_I_QL, S_I_QH, S_I_QD, S_I_A0, S_I_SEG, S_I_ACC, S_I_LAST,
    S_IP_MUL, S_IP_DONE
  } state_t;

  // halve with truncation toward zero
  function automatic logic signed [PW-1:0] half_p(input logic signed [PW-1:0] p);
    return (p + $signed(PW'({1'b0, p[PW-1]}))) >>> 1;
  endfunction

  function automatic logic [AVW-1:0] sat64(input logic signed [QW-1:0] v);
    logic [QW-AVW:0] top;
    top = v[QW-1:AVW-1];
    if ((&top) || !(|top)) return v[AVW-1:0];
    else if (v[QW-1]) return {1'b1, {(AVW-1){1'b0}}};
    else return {1'b0, {(AVW-1){1'b1}}};
  endfunction

  function automatic logic [XW-1:0] sat32(input logic signed [QW-1:0] v);
    logic [QW-XW:0] top;
    top = v[QW-1:XW-1];
    if ((&top) || !(|top)) return v[XW-1:0];
    else if (v[QW-1]) return {1'b1, {(XW-1){1'b0}}};
    else return {1'b0, {(XW-1){1'b1}}};
  endfunction

endpackage

// File: src/piecewise_linear_curve_table.sv
// channel | signals                                          | role
// --------+--------------------------------------------------+---------------------------
// in      | in_valid, in_ready, req_type, point_x, point_y,  | request transaction
//         | query_value                                      |
// out     | out_valid, out_ready, curve_value, area_value,   | one result transaction per
//         | status, keys_increasing, point_count             | request
//
// append, clear, unknown and short-table requests: go from idle straight to the finish
//   state, which raises out_valid once any earlier result has been taken, then returns to idle
// lookup / inverse lookup: one table entry read per cycle, then a 96-step restoring
//   divider for the interpolation
// integrate: read, multiply and accumulate per segment over the single registered
//   multiplier, plus one divider pass
// rst is synchronous; it empties the table (count 0), the point memories keep garbage
// a result waiting on out_ready holds the output register; a new request is taken
// as soon as the sequencer is back in idle
module piecewise_linear_curve_table (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic        [pwlct_pkg::REQW-1:0]       req_type,
  input  logic signed [pwlct_pkg::XW-1:0]         point_x,
  input  logic signed [pwlct_pkg::XW-1:0]         point_y,
  input  logic signed [pwlct_pkg::XW-1:0]         query_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pwlct_pkg::XW-1:0]         curve_value,
  output logic signed [pwlct_pkg::AVW-1:0]        area_value,
  output logic        [pwlct_pkg::STW-1:0]        status,
  output logic                                    keys_increasing,
  output logic        [pwlct_pkg::PCW-1:0]        point_count
);
  import pwlct_pkg::*;

  state_t state, state_next, ret, ret_next;

  // table state
  logic        [CW-1:0] count;
  logic                 incr;
  logic signed [XW-1:0] last_x;

  // point memories, registered read
  logic signed [XW-1:0] x_mem [MAX_POINTS];
  logic signed [XW-1:0] y_mem [MAX_POINTS];
  logic        [AW-1:0] rd_addr;
  logic signed [XW-1:0] rd_x, rd_y;
  logic                 mem_we;

  // request being worked
  logic [REQW-1:0]      op;
  logic signed [XW-1:0] q;
  logic signed [XW-1:0] prev_k, prev_v;
  logic signed [XW:0]   dk;
  logic        [AW-1:0] idx;
  logic        [XW-1:0] qq_hi;

  // shared multiplier
  logic                  mul_go;
  logic signed [OPW-1:0] mul_a, mul_b, op_a, op_b;
  logic signed [PW-1:0]  mul_p, plo, half_prod;

  // shared divider
  logic                  div_go;
  logic signed [QW-1:0]  div_n;
  logic signed [DVW-1:0] div_d;
  logic        [NW-1:0]  dv_num;
  logic        [DVW:0]   dv_rem, rem_sh;
  logic        [DVW-1:0] dv_den;
  logic                  dv_neg, dv_ge;
  logic        [DCW-1:0] dv_cnt;
  logic signed [QW-1:0]  dv_quot;

  logic signed [ACW-1:0] acc, acc_new;

  // result under construction
  logic signed [XW-1:0]  res_curve;
  logic signed [AVW-1:0] res_area;
  logic        [STW-1:0] res_status;

  // derived values
  logic signed [XW-1:0]  k_rd, v_rd;
  logic signed [XW:0]    d_k, d_q, d_v, sum_v;
  logic signed [PW-1:0]  mean_w;
  logic signed [QW-1:0]  ip_val;
  logic signed [OPW-1:0] yq_sum;
  logic                  at_last, accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  // inverse lookup swaps the roles of the two memories
  assign k_rd = (op == REQ_INVERSE) ? rd_y : rd_x;
  assign v_rd = (op == REQ_INVERSE) ? rd_x : rd_y;

  assign d_k    = {k_rd[XW-1], k_rd} - {prev_k[XW-1], prev_k};
  assign d_q    = {q[XW-1], q} - {prev_k[XW-1], prev_k};
  assign d_v    = {v_rd[XW-1], v_rd} - {prev_v[XW-1], prev_v};
  assign sum_v  = {v_rd[XW-1], v_rd} + {prev_v[XW-1], prev_v};
  assign mean_w = half_p(PW'(sum_v));

  assign half_prod = half_p(mul_p);
  assign acc_new   = acc + ACW'(half_prod);
  assign dv_quot   = dv_neg ? -$signed({1'b0, dv_num}) : $signed({1'b0, dv_num});
  assign ip_val    = QW'(prev_v) + dv_quot;
  assign yq_sum    = OPW'(prev_v) + OPW'(ip_val);
  assign at_last   = (CW'(idx) == count - CW'(1));

  assign rem_sh = {dv_rem[DVW-1:0], dv_num[NW-1]};
  assign dv_ge  = (rem_sh >= {1'b0, dv_den});

  // memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      x_mem[AW'(count)] <= point_x;
      y_mem[AW'(count)] <= point_y;
    end
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    ret_next   = ret;
    rd_addr    = '0;
    mem_we     = 1'b0;
    mul_go     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_go     = 1'b0;
    div_n      = '0;
    div_d      = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_FIN;
          if (req_type == REQ_APPEND && count != CW'(MAX_POINTS)) mem_we = 1'b1;
          if (req_type == REQ_LOOKUP || req_type == REQ_INVERSE || req_type == REQ_INTEG) begin
            if (count >= CW'(2))
              state_next = (req_type == REQ_INTEG) ? S_I_FIRST : S_L_FIRST;
          end
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      S_MWAIT: state_next = ret;
      S_DIV: begin
        if (dv_cnt == DCW'(1)) state_next = ret;
      end
      S_L_FIRST: begin
        if (q <= k_rd) state_next = S_FIN;
        else begin
          rd_addr    = AW'(count - CW'(1));
          state_next = S_L_LAST;
        end
      end
      S_L_LAST: begin
        if (q >= k_rd) state_next = S_FIN;
        else begin
          rd_addr    = AW'(1);
          state_next = S_L_SCAN;
        end
      end
      S_L_SCAN: begin
        if (k_rd > q) begin
          if (d_k == '0) state_next = S_FIN;
          else begin
            mul_go = 1'b1; mul_a = OPW'(d_q); mul_b = OPW'(d_v);
            ret_next = S_IP_MUL; state_next = S_MWAIT;
          end
        end else if (at_last) begin
          state_next = S_FIN;
        end else begin
          rd_addr = idx + AW'(1);
        end
      end
      S_I_FIRST: begin
        if (q <= k_rd) begin
          if (k_rd > 0) begin
            mul_go = 1'b1; mul_a = OPW'(q); mul_b = OPW'(q);
            ret_next = S_I_QQ; state_next = S_MWAIT;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          mul_go = 1'b1; mul_a = OPW'(v_rd); mul_b = OPW'(k_rd);
          ret_next = S_I_A0; state_next = S_MWAIT;
        end
      end
      S_I_QQ: begin
        mul_go = 1'b1; mul_a = OPW'(prev_v); mul_b = OPW'({1'b0, mul_p[XW-1:0]});
        ret_next = S_I_QL; state_next = S_MWAIT;
      end
      S_I_QL: begin
        mul_go = 1'b1; mul_a = OPW'(prev_v); mul_b = OPW'({1'b0, qq_hi});
        ret_next = S_I_QH; state_next = S_MWAIT;
      end
      S_I_QH: begin
        div_go = 1'b1;
        div_n  = (QW'(mul_p) <<< XW) + QW'(plo);
        div_d  = DVW'($signed({prev_k, 1'b0}));
        ret_next = S_I_QD; state_next = S_DIV;
      end
      S_I_QD: state_next = S_FIN;
      S_I_A0: begin
        rd_addr    = AW'(1);
        state_next = S_I_SEG;
      end
      S_I_SEG: begin
        if (q <= k_rd) begin
          if (d_k <= 0) state_next = S_FIN;
          else begin
            mul_go = 1'b1; mul_a = OPW'(d_q); mul_b = OPW'(d_v);
            ret_next = S_IP_MUL; state_next = S_MWAIT;
          end
        end else begin
          mul_go = 1'b1; mul_a = OPW'(sum_v); mul_b = OPW'(d_k);
          ret_next = S_I_ACC; state_next = S_MWAIT;
        end
      end
      S_I_ACC: begin
        if (at_last) state_next = S_FIN;
        else begin
          rd_addr    = idx + AW'(1);
          state_next = S_I_SEG;
        end
      end
      S_I_LAST: state_next = S_FIN;
      S_IP_MUL: begin
        div_go = 1'b1;
        div_n  = QW'(mul_p);
        div_d  = DVW'(dk);
        ret_next = S_IP_DONE; state_next = S_DIV;
      end
      S_IP_DONE: begin
        if (op == REQ_INTEG) begin
          mul_go = 1'b1; mul_a = OPW'(d_q); mul_b = yq_sum;
          ret_next = S_I_LAST; state_next = S_MWAIT;
        end else begin
          state_next = S_FIN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    mul_p <= PW'(op_a) * PW'(op_b);
    if (mul_go) begin
      op_a <= mul_a;
      op_b <= mul_b;
    end
    if (mul_go || div_go) ret <= ret_next;
    if (div_go) begin
      dv_num <= div_n[QW-1] ? NW'(-div_n) : NW'(div_n);
      dv_den <= div_d[DVW-1] ? DVW'(-div_d) : DVW'(div_d);
      dv_neg <= div_n[QW-1] ^ div_d[DVW-1];
      dv_rem <= '0;
      dv_cnt <= DCW'(NW);
    end else if (state == S_DIV) begin
      // restoring step: quotient bits shift in where dividend bits leave
      dv_rem <= dv_ge ? rem_sh - {1'b0, dv_den} : rem_sh;
      dv_num <= {dv_num[NW-2:0], dv_ge};
      dv_cnt <= dv_cnt - DCW'(1);
    end

    if (rst) begin
      count     <= '0;
      incr      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // the finish state reloads the output register itself
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op         <= req_type;
            q          <= query_value;
            res_curve  <= '0;
            res_area   <= '0;
            if (req_type == REQ_APPEND) begin
              if (count == CW'(MAX_POINTS)) res_status <= ST_FULL;
              else begin
                res_status <= ST_OK;
                if (count == CW'(1)) incr <= (point_x > last_x);
                else if (count > CW'(1)) incr <= incr && (point_x > last_x);
                last_x <= point_x;
                count  <= count + CW'(1);
              end
            end else if (req_type == REQ_CLEAR) begin
              res_status <= ST_OK;
              count      <= '0;
              incr       <= 1'b0;
            end else if (req_type == REQ_LOOKUP || req_type == REQ_INVERSE ||
                         req_type == REQ_INTEG) begin
              res_status <= (count < CW'(2)) ? ST_FEW : ST_OK;
            end else begin
              res_status <= ST_OK;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            curve_value     <= res_curve;
            area_value      <= res_area;
            status          <= res_status;
            keys_increasing <= incr;
            point_count     <= PCW'(count);
          end
        end
        S_L_FIRST: begin
          prev_k <= k_rd;
          prev_v <= v_rd;
          if (q <= k_rd) res_curve <= v_rd;
        end
        S_L_LAST: begin
          idx <= AW'(1);
          if (q >= k_rd) res_curve <= v_rd;
        end
        S_L_SCAN: begin
          if (k_rd > q) begin
            dk <= d_k;
            if (d_k == '0) res_curve <= sat32(QW'(mean_w));
          end else begin
            prev_k <= k_rd;
            prev_v <= v_rd;
            idx    <= idx + AW'(1);
          end
        end
        S_I_FIRST: begin
          prev_k <= k_rd;
          prev_v <= v_rd;
        end
        S_I_QQ: qq_hi <= mul_p[2*XW-1:XW];
        S_I_QL: plo <= mul_p;
        S_I_QD: res_area <= sat64(dv_quot);
        S_I_A0: begin
          acc <= ACW'(half_prod);
          idx <= AW'(1);
        end
        S_I_SEG: begin
          if (q <= k_rd) begin
            dk <= d_k;
            if (d_k <= 0) res_area <= sat64(QW'(acc));
          end else begin
            prev_k <= k_rd;
            prev_v <= v_rd;
          end
        end
        S_I_ACC: begin
          acc      <= acc_new;
          idx      <= idx + AW'(1);
          res_area <= sat64(QW'(acc_new));
        end
        S_I_LAST: res_area <= sat64(QW'(acc_new));
        S_IP_DONE: begin
          if (op != REQ_INTEG) res_curve <= sat32(ip_val);
        end
        default: ;
      endcase
    end
  end

endmodule
